FILE: src/gtb_pkg.sv
// Shared types and constants of the glyph text blitter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package gtb_pkg;

   // Font geometry
   localparam int GLYPH_WIDTH  = 8;
   localparam int GLYPH_HEIGHT = 16;
   localparam int GLYPH_STRIDE = 16;
   localparam int ROW_W        = $clog2(GLYPH_HEIGHT);
   localparam logic [ROW_W-1:0] LAST_GLYPH_ROW = ROW_W'(GLYPH_HEIGHT - 1);

   // Font store
   localparam int FONT_DEPTH = 4096;
   localparam int FONT_AW    = $clog2(FONT_DEPTH);

   // Field widths
   localparam int KIND_W  = 2;
   localparam int CODE_W  = 8;
   localparam int COORD_W = 16;
   localparam int COLOR_W = 32;
   localparam int SIZE_W  = 13;
   localparam int PITCH_W = 14;
   localparam int LINE_W  = 12;
   localparam int ADDR_W  = 27;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH  = 2'd2;

   localparam logic [GLYPH_WIDTH-1:0] LEFT_COL_BIT = 8'h80;
   localparam logic signed [COORD_W-1:0] CURSOR_MAX = 16'sd32767;

   // One glyph row read issued to the font store, aligned with its read data
   typedef struct packed {
      logic                   valid;
      logic [SIZE_W-1:0]      line;
      logic                   last;
      logic [GLYPH_WIDTH-1:0] cols;
   } issue_type;

   // Per-character context that stays fixed while a character is drawn
   typedef struct packed {
      logic signed [COORD_W-1:0] left_x;
      logic [COLOR_W-1:0]        fore;
      logic [COLOR_W-1:0]        back;
      logic                      see;
      logic [PITCH_W-1:0]        pitch;
   } ctx_type;

endpackage

FILE: src/gtb_font_ram.sv
// Font store: single-port-write, single-port-read synchronous memory.
// Depends on gtb_pkg for its geometry.
`timescale 1ns / 1ps

module gtb_font_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [gtb_pkg::FONT_AW-1:0] wr_addr,
   input  logic [7:0]                wr_data,
   input  logic                      rd_en,
   input  logic [gtb_pkg::FONT_AW-1:0] rd_addr,
   output logic [7:0]                rd_data
);

   logic [7:0] mem [gtb_pkg::FONT_DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: src/gtb_row_seq.sv
// Item intake, held text state, configuration registers and the row sequencer
// that issues one font read per visible glyph row. Depends on gtb_pkg.
`timescale 1ns / 1ps

module gtb_row_seq (
   input  logic clock,
   input  logic reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [gtb_pkg::KIND_W-1:0]          req_kind,
   input  logic [gtb_pkg::FONT_AW-1:0]         req_font_index,
   input  logic [7:0]                          req_font_bits,
   input  logic signed [gtb_pkg::COORD_W-1:0]  req_start_x,
   input  logic signed [gtb_pkg::COORD_W-1:0]  req_start_y,
   input  logic [gtb_pkg::COLOR_W-1:0]         req_fore_color,
   input  logic [gtb_pkg::COLOR_W-1:0]         req_back_color,
   input  logic                                req_see_through,
   input  logic [gtb_pkg::CODE_W-1:0]          req_char_code,

   input  logic                                csr_write,
   input  logic [gtb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gtb_pkg::CSR_DATA_W-1:0]      csr_wdata,

   // Font store ports
   output logic                                font_wr_en,
   output logic [gtb_pkg::FONT_AW-1:0]         font_wr_addr,
   output logic [7:0]                          font_wr_data,
   output logic                                font_rd_en,
   output logic [gtb_pkg::FONT_AW-1:0]         font_rd_addr,

   // To the row formatter
   input  logic                                issue_ok,
   output gtb_pkg::issue_type                  issue,
   output gtb_pkg::ctx_type                    ctx
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DRAW = 1'b1;

   logic state_ff, state_in;
   logic [gtb_pkg::ROW_W-1:0] row_ff, row_in;
   logic [gtb_pkg::CODE_W-1:0] code_ff, code_in;
   logic [gtb_pkg::GLYPH_WIDTH-1:0] cols_ff, cols_in;
   logic signed [gtb_pkg::COORD_W-1:0] left_x_ff, left_x_in;
   logic signed [gtb_pkg::COORD_W-1:0] cursor_ff, cursor_in;
   logic signed [gtb_pkg::COORD_W-1:0] top_ff, top_in;
   logic [gtb_pkg::COLOR_W-1:0] fore_ff, fore_in;
   logic [gtb_pkg::COLOR_W-1:0] back_ff, back_in;
   logic see_ff, see_in;
   logic [gtb_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [gtb_pkg::SIZE_W-1:0] height_ff, height_in;
   logic [gtb_pkg::PITCH_W-1:0] pitch_ff, pitch_in;
   gtb_pkg::issue_type issue_ff, issue_in;

   logic accept;
   logic [gtb_pkg::GLYPH_WIDTH-1:0] cols_now;
   logic [gtb_pkg::COORD_W:0] cursor_next;
   logic signed [gtb_pkg::COORD_W:0] py;
   logic [gtb_pkg::COORD_W:0] py_plus;
   logic vis;
   logic last;
   logic fire;
   logic advance;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff == ST_DRAW);

   // Columns of the cell at the cursor that fall inside the surface width
   always_comb begin
      logic signed [gtb_pkg::COORD_W+1:0] px;
      cols_now = '0;
      for (int c = 0; c < gtb_pkg::GLYPH_WIDTH; c++) begin
         px = (gtb_pkg::COORD_W+2)'(cursor_ff) + (gtb_pkg::COORD_W+2)'(c);
         if (!px[gtb_pkg::COORD_W+1] &&
             (px[gtb_pkg::COORD_W:0] < (gtb_pkg::COORD_W+1)'(width_ff))) begin
            cols_now = cols_now | (gtb_pkg::LEFT_COL_BIT >> c);
         end
      end
   end

   // Cursor advance by one cell, saturating at the top of the signed range
   assign cursor_next = (gtb_pkg::COORD_W+1)'(cursor_ff)
                        + (gtb_pkg::COORD_W+1)'(gtb_pkg::GLYPH_WIDTH);

   // Visibility of the current glyph row; visible rows form one run, so a visible
   // row is last when it ends the glyph or the next line falls below the surface.
   assign py      = (gtb_pkg::COORD_W+1)'(top_ff) + (gtb_pkg::COORD_W+1)'(row_ff);
   assign py_plus = py + 1'b1;
   assign vis     = !py[gtb_pkg::COORD_W] &&
                    (py[gtb_pkg::COORD_W-1:0] < gtb_pkg::COORD_W'(height_ff));
   assign last    = (row_ff == gtb_pkg::LAST_GLYPH_ROW) ||
                    !(py_plus < (gtb_pkg::COORD_W+1)'(height_ff));
   assign fire    = (state_ff == ST_DRAW) && vis && issue_ok;
   assign advance = (state_ff == ST_DRAW) && (!vis || issue_ok);

   // Font store access
   assign font_wr_en   = accept && (req_kind == gtb_pkg::KIND_LOAD);
   assign font_wr_addr = req_font_index;
   assign font_wr_data = req_font_bits;
   assign font_rd_en   = fire;
   assign font_rd_addr = gtb_pkg::FONT_AW'(
      gtb_pkg::FONT_AW'(code_ff) * gtb_pkg::FONT_AW'(gtb_pkg::GLYPH_STRIDE)
      + gtb_pkg::FONT_AW'(row_ff));

   // Next-state logic
   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      code_in   = code_ff;
      cols_in   = cols_ff;
      left_x_in = left_x_ff;
      cursor_in = cursor_ff;
      top_in    = top_ff;
      fore_in   = fore_ff;
      back_in   = back_ff;
      see_in    = see_ff;
      width_in  = width_ff;
      height_in = height_ff;
      pitch_in  = pitch_ff;

      issue_in       = '0;
      issue_in.valid = fire;
      issue_in.line  = py[gtb_pkg::SIZE_W-1:0];
      issue_in.last  = last;
      issue_in.cols  = cols_ff;

      if (csr_write) begin
         unique case (csr_index)
            gtb_pkg::CSR_WIDTH:  width_in  = gtb_pkg::SIZE_W'(csr_wdata);
            gtb_pkg::CSR_HEIGHT: height_in = gtb_pkg::SIZE_W'(csr_wdata);
            gtb_pkg::CSR_PITCH:  pitch_in  = csr_wdata;
            default: ;
         endcase
      end

      if (accept) begin
         unique case (req_kind)
            gtb_pkg::KIND_START: begin
               cursor_in = req_start_x;
               top_in    = req_start_y;
               fore_in   = req_fore_color;
               back_in   = req_back_color;
               see_in    = req_see_through;
            end
            gtb_pkg::KIND_DRAW: begin
               code_in   = req_char_code;
               cols_in   = cols_now;
               left_x_in = cursor_ff;
               row_in    = '0;
               if (cols_now != '0) begin
                  state_in = ST_DRAW;
               end
               if (!cursor_next[gtb_pkg::COORD_W] && cursor_next[gtb_pkg::COORD_W-1]) begin
                  cursor_in = gtb_pkg::CURSOR_MAX;
               end else begin
                  cursor_in = cursor_next[gtb_pkg::COORD_W-1:0];
               end
            end
            default: ;
         endcase
      end

      // Step through the glyph rows, one per cycle when there is room
      if (advance) begin
         if (row_ff == gtb_pkg::LAST_GLYPH_ROW) begin
            state_in = ST_IDLE;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issue_ff  <= '0;
         cursor_ff <= '0;
         top_ff    <= '0;
         fore_ff   <= '0;
         back_ff   <= '0;
         see_ff    <= 1'b0;
         width_ff  <= '0;
         height_ff <= '0;
         pitch_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         issue_ff  <= issue_in;
         cursor_ff <= cursor_in;
         top_ff    <= top_in;
         fore_ff   <= fore_in;
         back_ff   <= back_in;
         see_ff    <= see_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         pitch_ff  <= pitch_in;
      end
   end

   // Per-character working registers
   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      code_ff   <= code_in;
      cols_ff   <= cols_in;
      left_x_ff <= left_x_in;
   end

   assign issue      = issue_ff;
   assign ctx.left_x = left_x_ff;
   assign ctx.fore   = fore_ff;
   assign ctx.back   = back_ff;
   assign ctx.see    = see_ff;
   assign ctx.pitch  = pitch_ff;

endmodule

FILE: src/gtb_row_fmt.sv
// Row formatter: turns font read data into masks and a framebuffer address,
// and holds results in a two-entry output queue. Depends on gtb_pkg.
`timescale 1ns / 1ps

module gtb_row_fmt (
   input  logic clock,
   input  logic reset,

   input  gtb_pkg::issue_type issue,
   input  gtb_pkg::ctx_type   ctx,
   input  logic [7:0]         font_data,
   output logic               issue_ok,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gtb_pkg::LINE_W-1:0]          rsp_row_line,
   output logic signed [gtb_pkg::COORD_W-1:0]  rsp_row_left_x,
   output logic signed [gtb_pkg::ADDR_W-1:0]   rsp_row_address,
   output logic [gtb_pkg::GLYPH_WIDTH-1:0]     rsp_write_mask,
   output logic [gtb_pkg::GLYPH_WIDTH-1:0]     rsp_fore_mask,
   output logic [gtb_pkg::COLOR_W-1:0]         rsp_out_fore,
   output logic [gtb_pkg::COLOR_W-1:0]         rsp_out_back,
   output logic                                rsp_last_row
);

   typedef struct packed {
      logic [gtb_pkg::LINE_W-1:0]      line;
      logic [gtb_pkg::COORD_W-1:0]     left_x;
      logic [gtb_pkg::ADDR_W-1:0]      addr;
      logic [gtb_pkg::GLYPH_WIDTH-1:0] wmask;
      logic [gtb_pkg::GLYPH_WIDTH-1:0] fmask;
      logic [gtb_pkg::COLOR_W-1:0]     fore;
      logic [gtb_pkg::COLOR_W-1:0]     back;
      logic                            last;
   } beat_type;

   beat_type q_ff [2];
   logic [1:0] count_ff, count_in;
   logic head_ff, head_in;

   beat_type beat;
   logic [gtb_pkg::ADDR_W-1:0] prod;
   logic push;
   logic pop;
   logic tail;
   logic [2:0] occupancy;

   // Masks and address of the row whose font byte has just been read
   assign prod = gtb_pkg::ADDR_W'(issue.line) * gtb_pkg::ADDR_W'(ctx.pitch);

   always_comb begin
      beat        = '0;
      beat.line   = issue.line[gtb_pkg::LINE_W-1:0];
      beat.left_x = ctx.left_x;
      beat.addr   = prod + gtb_pkg::ADDR_W'(ctx.left_x);
      beat.fmask  = font_data & issue.cols;
      beat.wmask  = ctx.see ? (font_data & issue.cols) : issue.cols;
      beat.fore   = ctx.fore;
      beat.back   = ctx.back;
      beat.last   = issue.last;
   end

   // Queue control; a read may issue only if its data will find a free slot
   assign push      = issue.valid;
   assign pop       = rsp_valid && !rsp_stall;
   assign tail      = head_ff ^ count_ff[0];
   assign occupancy = 3'(count_ff) + 3'(issue.valid) - 3'(pop);
   assign issue_ok  = (occupancy <= 3'd1);

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      if (pop) begin
         head_in = !head_ff;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail] <= beat;
      end
   end

   // Result channel
   assign rsp_valid       = (count_ff != 2'd0);
   assign rsp_row_line    = q_ff[head_ff].line;
   assign rsp_row_left_x  = q_ff[head_ff].left_x;
   assign rsp_row_address = q_ff[head_ff].addr;
   assign rsp_write_mask  = q_ff[head_ff].wmask;
   assign rsp_fore_mask   = q_ff[head_ff].fmask;
   assign rsp_out_fore    = q_ff[head_ff].fore;
   assign rsp_out_back    = q_ff[head_ff].back;
   assign rsp_last_row    = q_ff[head_ff].last;

endmodule

FILE: src/glyph_text_blitter_top.sv
// Glyph text blitter: renders 8x16 bitmap-font text as framebuffer row writes.
//
// Input channel (req_*): each beat is a font byte load, a string start or a
// character draw, chosen by req_kind. A load writes one byte of the 4096-entry
// font memory; a start sets the cursor, text top line, colours and
// see-through flag. Neither gives a result. A draw gives one result beat per
// glyph row that lies inside the surface; rsp_last_row marks the final one.
// Result channel (rsp_*): row line, left column, address, write and
// foreground masks and the two colours, from a two-entry output queue.
// Configuration (csr_*): surface width, height and line pitch, written only
// while the block is idle; the user must keep to this, it is not enforced.
// Throughput: a load or start is taken at once while idle. A draw holds
// req_stall while it steps the glyph rows, one glyph row per cycle while the
// output queue has room, set by the single read port of the font memory; with
// no visible column it does not stall. A stalled receiver holds the row
// sequence once the output queue is full. Reset clears all control and held
// state; the font memory is not cleared and must be loaded before use.
// Depends on gtb_pkg, gtb_font_ram, gtb_row_seq and gtb_row_fmt.
`timescale 1ns / 1ps

module glyph_text_blitter_top (
   input  logic clock,
   input  logic reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [gtb_pkg::KIND_W-1:0]          req_kind,
   input  logic [gtb_pkg::FONT_AW-1:0]         req_font_index,
   input  logic [7:0]                          req_font_bits,
   input  logic signed [gtb_pkg::COORD_W-1:0]  req_start_x,
   input  logic signed [gtb_pkg::COORD_W-1:0]  req_start_y,
   input  logic [gtb_pkg::COLOR_W-1:0]         req_fore_color,
   input  logic [gtb_pkg::COLOR_W-1:0]         req_back_color,
   input  logic                                req_see_through,
   input  logic [gtb_pkg::CODE_W-1:0]          req_char_code,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gtb_pkg::LINE_W-1:0]          rsp_row_line,
   output logic signed [gtb_pkg::COORD_W-1:0]  rsp_row_left_x,
   output logic signed [gtb_pkg::ADDR_W-1:0]   rsp_row_address,
   output logic [gtb_pkg::GLYPH_WIDTH-1:0]     rsp_write_mask,
   output logic [gtb_pkg::GLYPH_WIDTH-1:0]     rsp_fore_mask,
   output logic [gtb_pkg::COLOR_W-1:0]         rsp_out_fore,
   output logic [gtb_pkg::COLOR_W-1:0]         rsp_out_back,
   output logic                                rsp_last_row,

   input  logic                                csr_write,
   input  logic [gtb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gtb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic                        font_wr_en;
   logic [gtb_pkg::FONT_AW-1:0] font_wr_addr;
   logic [7:0]                  font_wr_data;
   logic                        font_rd_en;
   logic [gtb_pkg::FONT_AW-1:0] font_rd_addr;
   logic [7:0]                  font_rd_data;
   logic                        issue_ok;
   gtb_pkg::issue_type          issue;
   gtb_pkg::ctx_type            ctx;

   // Intake and row sequencing
   gtb_row_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_font_index  (req_font_index),
      .req_font_bits   (req_font_bits),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_fore_color  (req_fore_color),
      .req_back_color  (req_back_color),
      .req_see_through (req_see_through),
      .req_char_code   (req_char_code),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .font_wr_en      (font_wr_en),
      .font_wr_addr    (font_wr_addr),
      .font_wr_data    (font_wr_data),
      .font_rd_en      (font_rd_en),
      .font_rd_addr    (font_rd_addr),
      .issue_ok        (issue_ok),
      .issue           (issue),
      .ctx             (ctx)
   );

   // Font memory
   gtb_font_ram u_font (
      .clock   (clock),
      .wr_en   (font_wr_en),
      .wr_addr (font_wr_addr),
      .wr_data (font_wr_data),
      .rd_en   (font_rd_en),
      .rd_addr (font_rd_addr),
      .rd_data (font_rd_data)
   );

   // Result formatting and output queue
   gtb_row_fmt u_fmt (
      .clock           (clock),
      .reset           (reset),
      .issue           (issue),
      .ctx             (ctx),
      .font_data       (font_rd_data),
      .issue_ok        (issue_ok),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_row_line    (rsp_row_line),
      .rsp_row_left_x  (rsp_row_left_x),
      .rsp_row_address (rsp_row_address),
      .rsp_write_mask  (rsp_write_mask),
      .rsp_fore_mask   (rsp_fore_mask),
      .rsp_out_fore    (rsp_out_fore),
      .rsp_out_back    (rsp_out_back),
      .rsp_last_row    (rsp_last_row)
   );

endmodule

FILE: src/gtb_checker.sv
// Port-level checks of the glyph text blitter, bound to the top level.
// Depends on gtb_pkg and glyph_text_blitter_top.
`timescale 1ns / 1ps

module gtb_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [gtb_pkg::ADDR_W-1:0]   rsp_row_address,
   input logic [gtb_pkg::GLYPH_WIDTH-1:0]     rsp_write_mask,
   input logic [gtb_pkg::GLYPH_WIDTH-1:0]     rsp_fore_mask
);

   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   // A stalled result beat keeps its address.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_row_address))
      else $error("result address changed while stalled");

   // Foreground pixels are always among the written ones.
   a_fore_in_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_fore_mask & ~rsp_write_mask) == '0))
      else $error("foreground mask outside write mask");

   // Reset empties the output queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat offered after reset");

endmodule

bind glyph_text_blitter_top gtb_checker u_gtb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_row_address (rsp_row_address),
   .rsp_write_mask  (rsp_write_mask),
   .rsp_fore_mask   (rsp_fore_mask)
);
